FILE: rtl/core/mpts_pkg.sv
// ----------------------------------------------------------------------------
// Multi-policy task scheduler package
// Shared codes, field widths and the scan flag group.
// ----------------------------------------------------------------------------
package mpts_pkg;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DECIDE
  } state_e;

  typedef enum logic [1:0] {
    POL_FIFO = 2'd0,
    POL_RR   = 2'd1,
    POL_SJF  = 2'd2,
    POL_SRTF = 2'd3
  } policy_e;

  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] CFG_POLICY  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_QUANTUM = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_COUNT   = 2'd2;

  localparam logic KIND_LOAD = 1'b0;
  localparam logic KIND_TICK = 1'b1;

  localparam int unsigned QUANT_W = 16;
  localparam int unsigned COUNT_W = 5;
  localparam int unsigned IDX_W   = 4;
  localparam int unsigned ARR_W   = 32;
  localparam int unsigned WORK_W  = 32;
  localparam int unsigned OTIME_W = 32;

  localparam int unsigned IN_TDATA_W  = 72;
  localparam int unsigned OUT_TDATA_W = 48;

  localparam logic [QUANT_W-1:0] QUANTUM_RESET = 16'd500;
  localparam logic [QUANT_W-1:0] QUANTUM_MAX   = 16'hFFFF;
  localparam logic [COUNT_W-1:0] COUNT_RESET   = 5'd16;

  typedef struct packed {
    logic first_found;
    logic best_found;
    logic hi_found;
    logic lo_found;
  } scan_flags_t;

endpackage

FILE: rtl/core/multi_policy_task_scheduler.sv
// ----------------------------------------------------------------------------
// Multi-policy task scheduler
// Load beats are written to the table as they are accepted. A tick beat scans
// n = min(entry_count, MAX_TASKS) entries, reading the table memory one entry
// per cycle; decide then selects and writes back when the output is free.
// The result register holds a finished tick while the next load is taken.
// Reset clears control state and sets configuration defaults; the task table
// is undefined until loaded and has no clearing pass.
// ----------------------------------------------------------------------------
module multi_policy_task_scheduler #(
  parameter int unsigned MAX_TASKS = 16,
  parameter int unsigned TIME_BITS = 32
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [mpts_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [mpts_pkg::CFG_DATA_W-1:0]     cfg_wdata_i,
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  // entry_index [3:0], arrival_time [35:4], work_amount [67:36], zero pad
  input  logic [mpts_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
  // kind [0]
  input  logic                                s_axis_tuser,
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  // running_valid [0], running_slot [4:1], context_switched [5],
  // finished_valid [6], finished_slot [10:7], tick_time [42:11],
  // all_done [43], zero pad
  output logic [mpts_pkg::OUT_TDATA_W-1:0]    m_axis_tdata
);

  localparam int unsigned SLOT_BITS = $clog2(MAX_TASKS);
  localparam int unsigned CNT_BITS  = $clog2(MAX_TASKS + 1);
  localparam int unsigned WW        = mpts_pkg::WORK_W;
  localparam int unsigned QW        = mpts_pkg::QUANT_W;

  mpts_pkg::state_e  state_q, state_d;
  mpts_pkg::policy_e policy_q;
  logic [QW-1:0]                    quantum_len_q;
  logic [mpts_pkg::COUNT_W-1:0]     entry_count_q;

  logic [SLOT_BITS-1:0] cur_slot_q, cur_slot_d;
  logic                 cur_valid_q, cur_valid_d;
  logic [QW-1:0]        quantum_q, quantum_d;
  logic [TIME_BITS-1:0] time_q, time_d;

  logic [CNT_BITS-1:0]  n_q, n_d;
  logic                 had_q, had_d;
  logic [CNT_BITS-1:0]  start_q, start_d;
  logic [CNT_BITS-1:0]  rd_cnt_q, rd_cnt_d;
  logic                 beat_vld_q;
  logic [SLOT_BITS-1:0] beat_idx_q;

  logic                         m_valid_q, m_valid_d;
  logic [mpts_pkg::OUT_TDATA_W-1:0] m_data_q, m_data_d;

  logic in_fire, is_tick, is_load, load_ok;
  logic scan_clear, rd_en, decide_go;
  logic [SLOT_BITS-1:0] rd_addr;

  logic [mpts_pkg::IDX_W-1:0] in_idx;
  logic [mpts_pkg::ARR_W-1:0] in_arr;
  logic [WW-1:0]              in_work;

  logic [TIME_BITS-1:0] arr_rdata;
  logic [WW-1:0]        rem_rdata;
  logic                 arr_we, rem_we;
  logic [SLOT_BITS-1:0] wr_addr;
  logic [TIME_BITS-1:0] arr_wdata;
  logic [WW-1:0]        rem_wdata;

  mpts_pkg::scan_flags_t flags;
  logic [CNT_BITS-1:0]   live;
  logic [WW-1:0]         cur_rem, first_rem, best_rem, hi_rem, lo_rem;
  logic [SLOT_BITS-1:0]  first_slot, best_slot, hi_slot, lo_slot;

  logic                 dead, cv2, q_over, nv, sw;
  logic [SLOT_BITS-1:0] ns;
  logic [WW-1:0]        nr;
  logic [QW-1:0]        qu1, qu2;

  assign in_idx  = s_axis_tdata[3:0];
  assign in_arr  = s_axis_tdata[35:4];
  assign in_work = s_axis_tdata[67:36];
  assign in_fire = s_axis_tvalid && s_axis_tready;
  assign is_tick = in_fire && (s_axis_tuser == mpts_pkg::KIND_TICK);
  assign is_load = in_fire && (s_axis_tuser == mpts_pkg::KIND_LOAD);
  assign load_ok = 32'(in_idx) < MAX_TASKS;

  // configuration
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      policy_q      <= mpts_pkg::POL_FIFO;
      quantum_len_q <= mpts_pkg::QUANTUM_RESET;
      entry_count_q <= mpts_pkg::COUNT_RESET;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        mpts_pkg::CFG_POLICY:  policy_q      <= mpts_pkg::policy_e'(cfg_wdata_i[1:0]);
        mpts_pkg::CFG_QUANTUM: quantum_len_q <= cfg_wdata_i;
        mpts_pkg::CFG_COUNT:   entry_count_q <= cfg_wdata_i[mpts_pkg::COUNT_W-1:0];
        default: ;
      endcase
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      mpts_pkg::ST_IDLE: begin
        if (is_tick) state_d = mpts_pkg::ST_SCAN;
      end
      mpts_pkg::ST_SCAN: begin
        if (rd_cnt_q == n_q) state_d = mpts_pkg::ST_DECIDE;
      end
      mpts_pkg::ST_DECIDE: begin
        if (!m_valid_q || m_axis_tready) state_d = mpts_pkg::ST_IDLE;
      end
      default: state_d = mpts_pkg::ST_IDLE;
    endcase
  end

  // state outputs
  always_comb begin
    s_axis_tready = 1'b0;
    rd_en         = 1'b0;
    decide_go     = 1'b0;
    case (state_q)
      mpts_pkg::ST_IDLE:   s_axis_tready = 1'b1;
      mpts_pkg::ST_SCAN:   rd_en = rd_cnt_q < n_q;
      mpts_pkg::ST_DECIDE: decide_go = !m_valid_q || m_axis_tready;
      default: ;
    endcase
  end

  assign scan_clear = is_tick;
  assign rd_addr    = rd_cnt_q[SLOT_BITS-1:0];

  // tick setup and scan address
  always_comb begin
    n_d      = n_q;
    had_d    = had_q;
    start_d  = start_q;
    rd_cnt_d = rd_cnt_q;
    if (is_tick) begin
      n_d      = (32'(entry_count_q) > MAX_TASKS) ? CNT_BITS'(MAX_TASKS)
                                                  : CNT_BITS'(entry_count_q);
      had_d    = cur_valid_q && (CNT_BITS'(cur_slot_q) < n_d);
      start_d  = had_d ? CNT_BITS'(cur_slot_q) + CNT_BITS'(1) : '0;
      rd_cnt_d = '0;
    end else if (rd_en) begin
      rd_cnt_d = rd_cnt_q + CNT_BITS'(1);
    end
  end

  // selection
  always_comb begin
    dead   = had_q && (cur_rem == '0);
    cv2    = had_q && !dead;
    qu1    = dead ? '0 : quantum_q;
    q_over = qu1 >= quantum_len_q;
    nv     = 1'b0;
    ns     = cur_slot_q;
    nr     = cur_rem;
    case (policy_q)
      mpts_pkg::POL_FIFO: begin
        if (cv2) begin
          nv = 1'b1;
        end else begin
          nv = flags.first_found;
          ns = first_slot;
          nr = first_rem;
        end
      end
      mpts_pkg::POL_RR: begin
        if (!cv2 || q_over) begin
          if (flags.hi_found) begin
            nv = 1'b1;
            ns = hi_slot;
            nr = hi_rem;
          end else begin
            nv = flags.lo_found;
            ns = lo_slot;
            nr = lo_rem;
          end
        end else begin
          nv = 1'b1;
        end
      end
      mpts_pkg::POL_SJF: begin
        if (cv2) begin
          nv = 1'b1;
        end else begin
          nv = flags.best_found;
          ns = best_slot;
          nr = best_rem;
        end
      end
      default: begin
        nv = flags.best_found;
        ns = best_slot;
        nr = best_rem;
      end
    endcase
    sw  = nv && (!cv2 || (ns != cur_slot_q));
    qu2 = q_over ? '0 : qu1;
    if (nv && (qu2 != mpts_pkg::QUANTUM_MAX)) begin
      qu2 = qu2 + QW'(1);
    end
  end

  // scheduler state and result register
  always_comb begin
    cur_slot_d  = cur_slot_q;
    cur_valid_d = cur_valid_q;
    quantum_d   = quantum_q;
    time_d      = time_q;
    m_valid_d   = m_valid_q;
    m_data_d    = m_data_q;
    if (m_axis_tready) begin
      m_valid_d = 1'b0;
    end
    if (decide_go) begin
      cur_slot_d  = nv ? ns : cur_slot_q;
      cur_valid_d = nv;
      quantum_d   = qu2;
      if ((live != '0) && (time_q != '1)) begin
        time_d = time_q + TIME_BITS'(1);
      end
      m_valid_d = 1'b1;
      m_data_d  = '0;
      m_data_d[0]     = nv;
      m_data_d[4:1]   = nv ? mpts_pkg::IDX_W'(ns) : '0;
      m_data_d[5]     = sw;
      m_data_d[6]     = dead;
      m_data_d[10:7]  = dead ? mpts_pkg::IDX_W'(cur_slot_q) : '0;
      m_data_d[42:11] = mpts_pkg::OTIME_W'(time_q);
      m_data_d[43]    = live == '0;
    end
  end

  // memory write port: loads from idle, work charge from decide
  always_comb begin
    arr_we    = is_load && load_ok;
    rem_we    = arr_we;
    wr_addr   = SLOT_BITS'(in_idx);
    arr_wdata = TIME_BITS'(in_arr);
    rem_wdata = in_work;
    if (decide_go) begin
      rem_we    = nv && (nr != '0);
      wr_addr   = ns;
      rem_wdata = nr - WW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= mpts_pkg::ST_IDLE;
      cur_slot_q  <= '0;
      cur_valid_q <= 1'b0;
      quantum_q   <= '0;
      time_q      <= '0;
      n_q         <= '0;
      had_q       <= 1'b0;
      start_q     <= '0;
      rd_cnt_q    <= '0;
      beat_vld_q  <= 1'b0;
      m_valid_q   <= 1'b0;
    end else begin
      state_q     <= state_d;
      cur_slot_q  <= cur_slot_d;
      cur_valid_q <= cur_valid_d;
      quantum_q   <= quantum_d;
      time_q      <= time_d;
      n_q         <= n_d;
      had_q       <= had_d;
      start_q     <= start_d;
      rd_cnt_q    <= rd_cnt_d;
      beat_vld_q  <= rd_en;
      m_valid_q   <= m_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    beat_idx_q <= rd_addr;
    m_data_q   <= m_data_d;
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;

  mpts_task_mem #(
    .DEPTH(MAX_TASKS),
    .AW   (SLOT_BITS),
    .TW   (TIME_BITS),
    .WW   (WW)
  ) u_mem (
    .clk_i      (clk_i),
    .rd_en_i    (rd_en),
    .rd_addr_i  (rd_addr),
    .arr_rdata_o(arr_rdata),
    .rem_rdata_o(rem_rdata),
    .arr_we_i   (arr_we),
    .rem_we_i   (rem_we),
    .wr_addr_i  (wr_addr),
    .arr_wdata_i(arr_wdata),
    .rem_wdata_i(rem_wdata)
  );

  mpts_scan #(
    .SLOT_BITS(SLOT_BITS),
    .CNT_BITS (CNT_BITS),
    .TIME_BITS(TIME_BITS)
  ) u_scan (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .clear_i     (scan_clear),
    .beat_vld_i  (beat_vld_q),
    .beat_idx_i  (beat_idx_q),
    .arr_i       (arr_rdata),
    .rem_i       (rem_rdata),
    .time_now_i  (time_q),
    .start_i     (start_q),
    .cur_slot_i  (cur_slot_q),
    .flags_o     (flags),
    .live_o      (live),
    .cur_rem_o   (cur_rem),
    .first_slot_o(first_slot),
    .first_rem_o (first_rem),
    .best_slot_o (best_slot),
    .best_rem_o  (best_rem),
    .hi_slot_o   (hi_slot),
    .hi_rem_o    (hi_rem),
    .lo_slot_o   (lo_slot),
    .lo_rem_o    (lo_rem)
  );

  a_tick_starts_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    is_tick |=> state_q == mpts_pkg::ST_SCAN)
    else $error("tick beat did not start a scan");

  a_rd_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == mpts_pkg::ST_SCAN |-> rd_cnt_q <= n_q)
    else $error("scan address ran past entry count");

  a_live_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == mpts_pkg::ST_DECIDE |-> live <= n_q)
    else $error("live count exceeds scanned entries");

  a_cur_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cur_valid_q |-> 32'(cur_slot_q) < MAX_TASKS)
    else $error("running slot outside table");

  a_no_rw_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rem_we |-> !rd_en)
    else $error("table write overlaps a scan read");

endmodule

FILE: rtl/core/mpts_task_mem.sv
// ----------------------------------------------------------------------------
// Task table memory
// Arrival and remaining-work arrays, one registered read port, one write port.
// ----------------------------------------------------------------------------
module mpts_task_mem #(
  parameter int unsigned DEPTH = 16,
  parameter int unsigned AW    = 4,
  parameter int unsigned TW    = 32,
  parameter int unsigned WW    = 32
) (
  input  logic          clk_i,
  input  logic          rd_en_i,
  input  logic [AW-1:0] rd_addr_i,
  output logic [TW-1:0] arr_rdata_o,
  output logic [WW-1:0] rem_rdata_o,
  input  logic          arr_we_i,
  input  logic          rem_we_i,
  input  logic [AW-1:0] wr_addr_i,
  input  logic [TW-1:0] arr_wdata_i,
  input  logic [WW-1:0] rem_wdata_i
);

  logic [TW-1:0] arr_mem [DEPTH];
  logic [WW-1:0] rem_mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (arr_we_i) begin
      arr_mem[wr_addr_i] <= arr_wdata_i;
    end
    if (rem_we_i) begin
      rem_mem[wr_addr_i] <= rem_wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      arr_rdata_o <= arr_mem[rd_addr_i];
      rem_rdata_o <= rem_mem[rd_addr_i];
    end
  end

endmodule

FILE: rtl/core/mpts_scan.sv
// ----------------------------------------------------------------------------
// Task table scan
// Folds one table entry per beat into the FIFO, shortest, rotating and
// live-count candidates.
// ----------------------------------------------------------------------------
module mpts_scan #(
  parameter int unsigned SLOT_BITS = 4,
  parameter int unsigned CNT_BITS  = 5,
  parameter int unsigned TIME_BITS = 32
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           clear_i,
  input  logic                           beat_vld_i,
  input  logic [SLOT_BITS-1:0]           beat_idx_i,
  input  logic [TIME_BITS-1:0]           arr_i,
  input  logic [mpts_pkg::WORK_W-1:0]    rem_i,
  input  logic [TIME_BITS-1:0]           time_now_i,
  input  logic [CNT_BITS-1:0]            start_i,
  input  logic [SLOT_BITS-1:0]           cur_slot_i,
  output mpts_pkg::scan_flags_t          flags_o,
  output logic [CNT_BITS-1:0]            live_o,
  output logic [mpts_pkg::WORK_W-1:0]    cur_rem_o,
  output logic [SLOT_BITS-1:0]           first_slot_o,
  output logic [mpts_pkg::WORK_W-1:0]    first_rem_o,
  output logic [SLOT_BITS-1:0]           best_slot_o,
  output logic [mpts_pkg::WORK_W-1:0]    best_rem_o,
  output logic [SLOT_BITS-1:0]           hi_slot_o,
  output logic [mpts_pkg::WORK_W-1:0]    hi_rem_o,
  output logic [SLOT_BITS-1:0]           lo_slot_o,
  output logic [mpts_pkg::WORK_W-1:0]    lo_rem_o
);

  mpts_pkg::scan_flags_t          flags_q, flags_d;
  logic                           stop_q, stop_d;
  logic [CNT_BITS-1:0]            live_q, live_d;
  logic [mpts_pkg::WORK_W-1:0]    cur_rem_q, cur_rem_d;
  logic [SLOT_BITS-1:0]           first_slot_q, first_slot_d;
  logic [mpts_pkg::WORK_W-1:0]    first_rem_q, first_rem_d;
  logic [SLOT_BITS-1:0]           best_slot_q, best_slot_d;
  logic [mpts_pkg::WORK_W-1:0]    best_rem_q, best_rem_d;
  logic [SLOT_BITS-1:0]           hi_slot_q, hi_slot_d;
  logic [mpts_pkg::WORK_W-1:0]    hi_rem_q, hi_rem_d;
  logic [SLOT_BITS-1:0]           lo_slot_q, lo_slot_d;
  logic [mpts_pkg::WORK_W-1:0]    lo_rem_q, lo_rem_d;

  logic arrived, nz, elig, scan_ok, upper;

  always_comb begin
    arrived = !(time_now_i < arr_i);
    nz      = rem_i != '0;
    elig    = arrived && nz;
    scan_ok = !stop_q && elig;
    upper   = CNT_BITS'(beat_idx_i) >= start_i;

    flags_d      = flags_q;
    stop_d       = stop_q;
    live_d       = live_q;
    cur_rem_d    = cur_rem_q;
    first_slot_d = first_slot_q;
    first_rem_d  = first_rem_q;
    best_slot_d  = best_slot_q;
    best_rem_d   = best_rem_q;
    hi_slot_d    = hi_slot_q;
    hi_rem_d     = hi_rem_q;
    lo_slot_d    = lo_slot_q;
    lo_rem_d     = lo_rem_q;

    if (clear_i) begin
      flags_d = '0;
      stop_d  = 1'b0;
      live_d  = '0;
    end else if (beat_vld_i) begin
      live_d = live_q + CNT_BITS'(nz);
      if (!arrived) begin
        stop_d = 1'b1;
      end
      if (beat_idx_i == cur_slot_i) begin
        cur_rem_d = rem_i;
      end
      if (scan_ok && !flags_q.first_found) begin
        flags_d.first_found = 1'b1;
        first_slot_d        = beat_idx_i;
        first_rem_d         = rem_i;
      end
      if (scan_ok && (!flags_q.best_found || best_rem_q > rem_i)) begin
        flags_d.best_found = 1'b1;
        best_slot_d        = beat_idx_i;
        best_rem_d         = rem_i;
      end
      if (elig && upper && !flags_q.hi_found) begin
        flags_d.hi_found = 1'b1;
        hi_slot_d        = beat_idx_i;
        hi_rem_d         = rem_i;
      end
      if (elig && !upper && !flags_q.lo_found) begin
        flags_d.lo_found = 1'b1;
        lo_slot_d        = beat_idx_i;
        lo_rem_d         = rem_i;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      flags_q <= '0;
      stop_q  <= 1'b0;
      live_q  <= '0;
    end else begin
      flags_q <= flags_d;
      stop_q  <= stop_d;
      live_q  <= live_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cur_rem_q    <= cur_rem_d;
    first_slot_q <= first_slot_d;
    first_rem_q  <= first_rem_d;
    best_slot_q  <= best_slot_d;
    best_rem_q   <= best_rem_d;
    hi_slot_q    <= hi_slot_d;
    hi_rem_q     <= hi_rem_d;
    lo_slot_q    <= lo_slot_d;
    lo_rem_q     <= lo_rem_d;
  end

  assign flags_o      = flags_q;
  assign live_o       = live_q;
  assign cur_rem_o    = cur_rem_q;
  assign first_slot_o = first_slot_q;
  assign first_rem_o  = first_rem_q;
  assign best_slot_o  = best_slot_q;
  assign best_rem_o   = best_rem_q;
  assign hi_slot_o    = hi_slot_q;
  assign hi_rem_o     = hi_rem_q;
  assign lo_slot_o    = lo_slot_q;
  assign lo_rem_o     = lo_rem_q;

endmodule

FILE: bench/multi_policy_task_scheduler_tb.sv
// ----------------------------------------------------------------------------
// Multi-policy task scheduler testbench
// Loads task tables and steps them tick by tick under FIFO, round robin, SJF
// and preemptive shortest-remaining, with random gaps on both streams. Every
// tick beat is predicted in the bench and each result beat is compared field
// by field against the oldest outstanding prediction.
// ----------------------------------------------------------------------------
module multi_policy_task_scheduler_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned SLOTS = 16;
  localparam int unsigned SETTLE_CYCLES = 24;
  localparam int unsigned RANDOM_ITEMS = 900;

  typedef struct packed {
    logic        run_valid;
    logic [3:0]  run_slot;
    logic        switched;
    logic        fin_valid;
    logic [3:0]  fin_slot;
    logic [31:0] tick_time;
    logic        all_done;
  } tick_report_t;

  logic                              clk_i = 1'b0;
  logic                              rst_ni;
  logic                              cfg_we_i;
  logic [mpts_pkg::CFG_IDX_W-1:0]    cfg_idx_i;
  logic [mpts_pkg::CFG_DATA_W-1:0]   cfg_wdata_i;
  logic                              s_axis_tvalid;
  logic                              s_axis_tready;
  logic [mpts_pkg::IN_TDATA_W-1:0]   s_axis_tdata;
  logic                              s_axis_tuser;
  logic                              m_axis_tvalid;
  logic                              m_axis_tready;
  logic [mpts_pkg::OUT_TDATA_W-1:0]  m_axis_tdata;

  // scheduler shadow state
  logic [31:0]        arr_tbl [SLOTS];
  logic [31:0]        work_left [SLOTS];
  int                 cur_slot;
  bit                 cur_valid;
  logic [15:0]        q_used;
  logic [31:0]        now_t;
  mpts_pkg::policy_e  pol_cfg;
  logic [15:0]        quant_cfg;
  logic [4:0]         cnt_cfg;

  tick_report_t pending_reports [$];

  bit          src_gaps;
  bit          sink_gaps;
  int unsigned hold_cycles;
  bit          last_done;

  int unsigned items_sent;
  int unsigned n_ticks;
  int unsigned n_loads;
  int unsigned n_phases;
  int unsigned n_checked;
  int unsigned n_finishes;
  int unsigned n_switches;
  int unsigned fail_count;
  int unsigned pol_ticks [4];

  multi_policy_task_scheduler uut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

  always #2 clk_i = ~clk_i;

  function automatic int shortest_ready(input int unsigned n);
    int best;
    best = -1;
    for (int i = 0; i < int'(n); i++) begin
      if (now_t < arr_tbl[i]) break;
      if (work_left[i] != 0 && (best < 0 || work_left[best] > work_left[i])) best = i;
    end
    return best;
  endfunction

  function automatic tick_report_t schedule_tick();
    tick_report_t rep;
    int unsigned  n;
    int unsigned  live;
    int unsigned  start;
    int unsigned  j;
    int           nxt;
    bit           had;
    bit           dead;
    rep = '0;
    nxt = -1;
    dead = 1'b0;
    n = (cnt_cfg > SLOTS) ? SLOTS : cnt_cfg;
    if (cur_valid && cur_slot >= int'(n)) cur_valid = 1'b0;
    had = cur_valid;
    if (had && work_left[cur_slot] == 0) begin
      rep.fin_valid = 1'b1;
      rep.fin_slot = cur_slot[3:0];
      dead = 1'b1;
      cur_valid = 1'b0;
      q_used = '0;
    end
    live = 0;
    for (int i = 0; i < int'(n); i++) if (work_left[i] != 0) live++;
    case (pol_cfg)
      mpts_pkg::POL_FIFO: begin
        if (cur_valid) begin
          nxt = cur_slot;
        end else begin
          for (int i = 0; i < int'(n); i++) begin
            if (now_t < arr_tbl[i]) break;
            if (work_left[i] != 0) begin
              nxt = i;
              break;
            end
          end
        end
      end
      mpts_pkg::POL_RR: begin
        if (!cur_valid || dead || q_used >= quant_cfg) begin
          start = had ? cur_slot + 1 : 0;
          for (int unsigned k = 0; k < n; k++) begin
            j = (start + k) % n;
            if (work_left[j] != 0 && now_t >= arr_tbl[j]) begin
              nxt = j;
              break;
            end
          end
        end else begin
          nxt = cur_slot;
        end
      end
      mpts_pkg::POL_SJF: nxt = cur_valid ? cur_slot : shortest_ready(n);
      default: nxt = shortest_ready(n);
    endcase
    rep.switched = (nxt >= 0) && (!cur_valid || nxt != cur_slot);
    if (q_used >= quant_cfg) q_used = '0;
    rep.tick_time = now_t;
    if (nxt >= 0) begin
      cur_slot = nxt;
      cur_valid = 1'b1;
      if (work_left[cur_slot] != 0) work_left[cur_slot] = work_left[cur_slot] - 1;
      if (q_used != mpts_pkg::QUANTUM_MAX) q_used = q_used + 16'd1;
      rep.run_valid = 1'b1;
      rep.run_slot = nxt[3:0];
    end else begin
      cur_valid = 1'b0;
    end
    if (live != 0 && now_t != 32'hFFFF_FFFF) now_t = now_t + 1;
    rep.all_done = (live == 0);
    pol_ticks[pol_cfg]++;
    if (rep.fin_valid) n_finishes++;
    if (rep.switched) n_switches++;
    return rep;
  endfunction

  task automatic write_reg(input logic [mpts_pkg::CFG_IDX_W-1:0] idx,
                           input logic [15:0] val);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      mpts_pkg::CFG_POLICY:  pol_cfg = mpts_pkg::policy_e'(val[1:0]);
      mpts_pkg::CFG_QUANTUM: quant_cfg = val;
      mpts_pkg::CFG_COUNT:   cnt_cfg = val[4:0];
      default: ;
    endcase
    @(posedge clk_i);
  endtask

  task automatic send_item(input logic kind, input logic [3:0] idx,
                           input logic [31:0] arr, input logic [31:0] work);
    int unsigned gap;
    gap = src_gaps ? $urandom_range(0, 7) : 0;
    if (gap != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser <= kind;
    s_axis_tdata <= {4'b0, work, arr, idx};
    do @(posedge clk_i); while (!s_axis_tready);
    items_sent++;
    if (kind == mpts_pkg::KIND_LOAD) begin
      arr_tbl[idx] = arr;
      work_left[idx] = work;
      n_loads++;
    end else begin
      pending_reports.push_back(schedule_tick());
      last_done = pending_reports[$].all_done;
      n_ticks++;
    end
  endtask

  task automatic load_slot(input logic [3:0] idx, input logic [31:0] arr,
                           input logic [31:0] work);
    send_item(mpts_pkg::KIND_LOAD, idx, arr, work);
  endtask

  task automatic tick(input int unsigned count);
    repeat (count) send_item(mpts_pkg::KIND_TICK, 4'($urandom), $urandom, $urandom);
  endtask

  // drain results, then let any load still in flight land
  task automatic settle();
    s_axis_tvalid <= 1'b0;
    while (pending_reports.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // result sink
  initial begin
    int unsigned w;
    m_axis_tready = 1'b0;
    @(posedge clk_i iff rst_ni);
    forever begin
      w = sink_gaps ? $urandom_range(0, 7) : 0;
      if (hold_cycles != 0) begin
        w = hold_cycles;
        hold_cycles = 0;
      end
      if (w != 0) begin
        m_axis_tready <= 1'b0;
        repeat (w) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk_i); while (!m_axis_tvalid);
    end
  end

  always @(posedge clk_i) begin
    tick_report_t got;
    tick_report_t exp_rep;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got.run_valid = m_axis_tdata[0];
      got.run_slot  = m_axis_tdata[4:1];
      got.switched  = m_axis_tdata[5];
      got.fin_valid = m_axis_tdata[6];
      got.fin_slot  = m_axis_tdata[10:7];
      got.tick_time = m_axis_tdata[42:11];
      got.all_done  = m_axis_tdata[43];
      if (pending_reports.size() == 0) begin
        if (fail_count < 10) $display("ERROR: result beat with nothing expected");
        fail_count++;
      end else begin
        exp_rep = pending_reports.pop_front();
        n_checked++;
        if (got !== exp_rep) begin
          if (fail_count < 10) begin
            $display("ERROR: result %0d mismatch", n_checked);
            $display("  exp run %b/%0d sw %b fin %b/%0d t %0d done %b",
                     exp_rep.run_valid, exp_rep.run_slot, exp_rep.switched,
                     exp_rep.fin_valid, exp_rep.fin_slot, exp_rep.tick_time,
                     exp_rep.all_done);
            $display("  got run %b/%0d sw %b fin %b/%0d t %0d done %b",
                     got.run_valid, got.run_slot, got.switched, got.fin_valid,
                     got.fin_slot, got.tick_time, got.all_done);
          end
          fail_count++;
        end
      end
    end
  end

  task automatic test_table_extremes();
    load_slot(4'd0, 32'd0, 32'd2);
    for (int i = 1; i < 15; i++) load_slot(i[3:0], 32'd0, 32'd0);
    load_slot(4'd15, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    tick(4);
    load_slot(4'd15, 32'd0, 32'd0);
    tick(2);
    settle();
  endtask

  task automatic test_reload_running();
    load_slot(4'd0, now_t, 32'd5);
    tick(2);
    load_slot(4'd0, 32'd0, 32'd0);
    tick(2);
    settle();
  endtask

  task automatic test_count_edges();
    write_reg(mpts_pkg::CFG_COUNT, 16'd8);
    load_slot(4'd6, now_t, 32'd4);
    tick(2);
    settle();
    write_reg(mpts_pkg::CFG_COUNT, 16'd4);
    tick(1);
    settle();
    write_reg(mpts_pkg::CFG_COUNT, 16'd0);
    tick(1);
    settle();
    write_reg(mpts_pkg::CFG_COUNT, 16'd31);
    write_reg(mpts_pkg::CFG_POLICY, 16'(mpts_pkg::POL_SRTF));
    tick(3);
    settle();
  endtask

  task automatic test_zero_quantum();
    write_reg(mpts_pkg::CFG_POLICY, 16'(mpts_pkg::POL_RR));
    write_reg(mpts_pkg::CFG_QUANTUM, 16'd0);
    write_reg(mpts_pkg::CFG_COUNT, 16'd3);
    for (int i = 0; i < 3; i++) load_slot(i[3:0], now_t, 32'd2);
    tick(8);
    settle();
  endtask

  task automatic test_backpressure();
    src_gaps = 1'b0;
    write_reg(mpts_pkg::CFG_POLICY, 16'(mpts_pkg::POL_RR));
    write_reg(mpts_pkg::CFG_QUANTUM, 16'd2);
    write_reg(mpts_pkg::CFG_COUNT, 16'd4);
    for (int i = 0; i < 4; i++) load_slot(i[3:0], now_t, 32'd6);
    hold_cycles = 120;
    tick(8);
    load_slot(4'd1, now_t, 32'd3);
    tick(8);
    load_slot(4'd3, now_t, 32'd0);
    tick(6);
    settle();
  endtask

  task automatic test_random_phases();
    int unsigned n;
    int unsigned noise;
    int unsigned done_seen;
    logic [31:0] arr;
    logic [31:0] work;
    logic [15:0] quant;
    logic [4:0]  cnt;
    while (items_sent < RANDOM_ITEMS) begin
      n_phases++;
      src_gaps = ($urandom_range(0, 3) != 0);
      sink_gaps = ($urandom_range(0, 3) != 0);
      case ($urandom_range(0, 9))
        0: quant = 16'd0;
        1: quant = mpts_pkg::QUANTUM_MAX;
        2: quant = 16'($urandom_range(6, 65534));
        default: quant = 16'($urandom_range(1, 5));
      endcase
      case ($urandom_range(0, 19))
        0: cnt = 5'd0;
        1: cnt = 5'($urandom_range(17, 31));
        default: cnt = 5'($urandom_range(1, 16));
      endcase
      write_reg(mpts_pkg::CFG_POLICY, 16'($urandom_range(0, 3)));
      write_reg(mpts_pkg::CFG_QUANTUM, quant);
      write_reg(mpts_pkg::CFG_COUNT, 16'(cnt));
      n = (cnt > SLOTS) ? SLOTS : cnt;
      arr = now_t + $urandom_range(0, 3);
      for (int unsigned s = 0; s < n; s++) begin
        noise = $urandom_range(0, 15);
        work = $urandom_range(1, 6);
        if (noise == 0) begin
          load_slot(s[3:0], $urandom, work);
        end else begin
          arr = arr + $urandom_range(0, 3);
          if (noise == 1) work = $urandom;
          else if (noise == 2) work = 32'd0;
          load_slot(s[3:0], arr, work);
        end
      end
      done_seen = 0;
      for (int t = 0; t < 48 && done_seen < 2; t++) begin
        if (n != 0 && $urandom_range(0, 11) == 0)
          load_slot(4'($urandom_range(0, n - 1)), now_t, $urandom_range(0, 4));
        tick(1);
        if (last_done) done_seen++;
      end
      settle();
    end
  endtask

  initial begin
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_idx_i = '0;
    cfg_wdata_i = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    s_axis_tuser = mpts_pkg::KIND_LOAD;
    src_gaps = 1'b1;
    sink_gaps = 1'b1;
    hold_cycles = 0;
    last_done = 1'b0;
    pol_cfg = mpts_pkg::POL_FIFO;
    quant_cfg = mpts_pkg::QUANTUM_RESET;
    cnt_cfg = mpts_pkg::COUNT_RESET;
    cur_slot = 0;
    cur_valid = 1'b0;
    q_used = '0;
    now_t = '0;
    for (int i = 0; i < SLOTS; i++) begin
      arr_tbl[i] = '0;
      work_left[i] = '0;
    end
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_table_extremes();
    test_reload_running();
    test_count_edges();
    test_zero_quantum();
    test_backpressure();
    test_random_phases();

    settle();
    fail_count += pending_reports.size();
    $display("Ran %0d ticks and %0d table loads over %0d random phases.",
             n_ticks, n_loads, n_phases);
    $display("Ticks per policy FIFO/RR/SJF/SRTF %0d/%0d/%0d/%0d, %0d finishes, %0d switches.",
             pol_ticks[0], pol_ticks[1], pol_ticks[2], pol_ticks[3], n_finishes,
             n_switches);
    if (fail_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("CHECK FAILED");
    $finish;
  end

endmodule
